/* src/ratiometric_adc_scan_sequencer_assert.svh */
// Assertion macros for the checker file of the scan sequencer.
`ifndef RATIOMETRIC_ADC_SCAN_SEQUENCER_ASSERT_SVH
`define RATIOMETRIC_ADC_SCAN_SEQUENCER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RASCAN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define RASCAN_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/rascan_pkg.sv */
// ----------------------------------------------------------------------------
// Scan sequencer package
// Beat types, action codes and the mux pin table.
// ----------------------------------------------------------------------------
package rascan_pkg;

  // Codes of the next_action field.
  localparam logic [1:0] ACT_NEXT_CHANNEL = 2'd0;
  localparam logic [1:0] ACT_SWITCH_MUX   = 2'd1;
  localparam logic [1:0] ACT_NONE         = 2'd2;

  // Codes of the command field.
  localparam logic CMD_CONVERSION = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  localparam logic [9:0] FULL_SCALE_RESET = 10'h3FF;

  // Select pins for each source: reference, then banks in order.
  localparam logic [2:0] PIN_CODES [8] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd6, 3'd3, 3'd5, 3'd7};

  typedef struct packed {
    logic       command;
    logic [2:0] channel;
    logic [9:0] sample;
    logic [3:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  next_action;
    logic [2:0]  next_channel;
    logic [2:0]  mux_pins;
    logic        all_valid;
    logic [19:0] read_value;
    logic        channel_error;
  } result_t;

  // Front queue head as seen by the back end.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } head_t;

  function automatic logic [2:0] pins_of(logic [2:0] src);
    return PIN_CODES[src];
  endfunction

endpackage

/* src/rascan_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rascan_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rascan_front.sv */
// ----------------------------------------------------------------------------
// Scan sequencer front queue
// Two-entry queue that takes input beats and holds them for the back end.
// ----------------------------------------------------------------------------
module rascan_front import rascan_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output head_t    head_o,
  input  logic     take_i
);

  logic [1:0] count_q, count_d;
  logic       wptr_q, rptr_q;
  in_item_t   slot_q [2];
  logic       do_push, do_take;

  assign full    = (count_q == 2'd2);
  assign do_push = push && !full;
  assign do_take = take_i && (count_q != 2'd0);

  // Occupancy follows pushes and takes.
  always_comb begin
    count_d = count_q;
    if (do_push && !do_take) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_take) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_take) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= in_item_i;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = slot_q[rptr_q];

endmodule

/* src/rascan_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of a 20-bit numerator by a 10-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module rascan_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [19:0] num_i,
  input  logic [9:0]  den_i,
  output logic        done_o,
  output logic [19:0] quo_o
);

  logic [19:0] quo_q;
  logic [9:0]  rem_q, den_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [10:0] shifted;
  logic        fits;

  // One trial subtraction per cycle.
  assign shifted = {rem_q, quo_q[19]};
  assign fits    = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd19) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= 10'd0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[18:0], fits};
      rem_q <= fits ? 10'(shifted - {1'b0, den_q}) : shifted[9:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* src/rascan_back.sv */
// ----------------------------------------------------------------------------
// Scan sequencer back end
// Decodes queued beats, steps the mux sequence, scales samples and keeps the table.
// ----------------------------------------------------------------------------
module rascan_back import rascan_pkg::*; #(
  parameter int CHANNELS_PER_BANK = 4,
  parameter int BANK_COUNT        = 4,
  parameter int TABLE_DEPTH       = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  head_t      head_i,
  output logic       take_o,
  input  logic [9:0] full_scale_i,
  output logic       empty,
  input  logic       pop,
  output result_t    result_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [2:0]  src_q;
  logic [9:0]  ref_q;
  logic        done_q;
  logic [TABLE_DEPTH-1:0] vld_q;

  result_t     res_q, out_q;
  logic        out_valid_q;
  logic [9:0]  den_q;
  logic [19:0] prod_q;
  logic [AW-1:0] addr_q;
  logic        rd_ok_q;

  in_item_t    it;
  logic        start;
  logic [6:0]  slot;
  logic        chan_err, advance, wrap;
  logic [2:0]  src_inc, src_next;
  logic        div_start, div_done;
  logic [19:0] quo;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [19:0] ram_wdata, ram_rdata;
  logic        load_out;

  assign it    = head_i.item;
  assign start = (state_q == S_IDLE) && head_i.valid;
  assign take_o = start;

  // Slot and sequencing decisions for the head beat.
  assign slot     = 7'(it.channel) + 7'(CHANNELS_PER_BANK) * 7'(3'(src_q - 3'd1));
  assign chan_err = (4'(it.channel) >= 4'(CHANNELS_PER_BANK)) ||
                    (slot >= 7'(TABLE_DEPTH));
  assign advance  = (src_q == 3'd0) || (4'(it.channel) >= 4'(CHANNELS_PER_BANK - 1));
  assign src_inc  = src_q + 3'd1;
  assign wrap     = ({1'b0, src_inc} > 4'(BANK_COUNT)) || (src_inc == 3'd0);
  assign src_next = wrap ? 3'd0 : src_inc;

  // Sequencer state machine.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (it.command == CMD_READ) begin
            state_d = S_RD;
          end else if (src_q != 3'd0 && !chan_err && ref_q != 10'd0) begin
            state_d = S_MUL;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_HOLD;
        end
      end
      S_RD: state_d = S_HOLD;
      S_HOLD: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign load_out  = (state_q == S_HOLD) && (!out_valid_q || pop);
  assign div_start = (state_q == S_MUL);

  // The table read starts at decode so that its data is ready in the read state.
  assign ram_raddr = start ? AW'(it.read_index) : addr_q;

  // Table writes: raw sample at decode, quotient when the divide ends.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = quo;
    if (start && it.command == CMD_CONVERSION && src_q != 3'd0 && !chan_err &&
        ref_q == 10'd0) begin
      ram_we    = 1'b1;
      ram_waddr = slot[AW-1:0];
      ram_wdata = 20'(it.sample);
    end else if (state_q == S_DIV && div_done) begin
      ram_we = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      src_q       <= 3'd0;
      ref_q       <= 10'd0;
      done_q      <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (start && it.command == CMD_CONVERSION) begin
        if (src_q == 3'd0) begin
          ref_q <= it.sample;
        end
        if (advance) begin
          src_q <= src_next;
          if (wrap) begin
            done_q <= 1'b1;
          end
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result assembly.
  always_ff @(posedge clk_i) begin
    if (start) begin
      den_q    <= ref_q;
      rd_ok_q  <= (7'(it.read_index) < 7'(TABLE_DEPTH));
      res_q.channel_error <= 1'b0;
      res_q.read_value    <= '0;
      if (it.command == CMD_READ) begin
        addr_q             <= AW'(it.read_index);
        res_q.next_action  <= ACT_NONE;
        res_q.next_channel <= 3'd0;
        res_q.mux_pins     <= pins_of(src_q);
        res_q.all_valid    <= done_q;
      end else begin
        addr_q <= slot[AW-1:0];
        if (advance) begin
          res_q.next_action  <= ACT_SWITCH_MUX;
          res_q.next_channel <= 3'd0;
          res_q.mux_pins     <= pins_of(src_next);
          res_q.all_valid    <= done_q || wrap;
        end else begin
          res_q.next_action  <= ACT_NEXT_CHANNEL;
          res_q.next_channel <= it.channel + 3'd1;
          res_q.mux_pins     <= pins_of(src_q);
          res_q.all_valid    <= done_q;
        end
        if (src_q == 3'd0) begin
          res_q.read_value <= 20'(it.sample);
        end else if (chan_err) begin
          res_q.channel_error <= 1'b1;
        end else if (ref_q == 10'd0) begin
          res_q.read_value <= 20'(it.sample);
        end
      end
    end else if (state_q == S_MUL) begin
      res_q.read_value <= res_q.read_value;
    end else if (state_q == S_DIV && div_done) begin
      res_q.read_value <= quo;
    end else if (state_q == S_RD) begin
      res_q.read_value <= (rd_ok_q && vld_q[addr_q]) ? ram_rdata : 20'd0;
    end
    if (state_q == S_IDLE && start && it.command == CMD_CONVERSION) begin
      prod_q <= 20'(it.sample) * 20'(full_scale_i);
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  rascan_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  rascan_ram #(.WIDTH(20), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

/* src/ratiometric_adc_scan_sequencer.sv */
// ----------------------------------------------------------------------------
// Ratiometric ADC scan sequencer
// Steps an analog mux through a reference and sample banks and scales samples.
// ----------------------------------------------------------------------------
// A read beat goes from decode through the read state to the hold state; a
// conversion beat that bank-stores a scaled sample passes the multiply and
// divide states, the divider giving one quotient bit per cycle, then the hold
// state; reference, raw-sample and dropped beats go straight from decode to
// the hold state. One beat is worked on at a time; a two-entry input queue
// and the result register let each side stall on its own. The table of scaled
// values reads as zero until written, with no clearing pass after reset.
module ratiometric_adc_scan_sequencer import rascan_pkg::*; #(
  parameter int CHANNELS_PER_BANK = 4,
  parameter int BANK_COUNT        = 4,
  parameter int TABLE_DEPTH       = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item_i,
  output logic       empty,
  input  logic       pop,
  output result_t    result_o,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i
);

  head_t      head;
  logic       take;
  logic [9:0] full_scale_q;

  // Full-scale configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RESET;
    end else if (cfg_we_i) begin
      full_scale_q <= cfg_wdata_i;
    end
  end

  rascan_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .head_o    (head),
    .take_i    (take)
  );

  rascan_back #(
    .CHANNELS_PER_BANK (CHANNELS_PER_BANK),
    .BANK_COUNT        (BANK_COUNT),
    .TABLE_DEPTH       (TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .take_o       (take),
    .full_scale_i (full_scale_q),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule

/* src/rascan_checker.sv */
// ----------------------------------------------------------------------------
// Scan sequencer checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "ratiometric_adc_scan_sequencer_assert.svh"

module rascan_checker import rascan_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input result_t    result_o
);

  `RASCAN_NEVER(a_action_code, !empty && result_o.next_action == 2'd3, "Undefined action code")
  `RASCAN_ASSERT(a_chan_zero, !empty && result_o.next_action != ACT_NEXT_CHANNEL |-> result_o.next_channel == 3'd0, "Channel not zero after a mux switch or read")
  `RASCAN_ASSERT(a_err_drop, !empty && result_o.channel_error |-> result_o.read_value == 20'd0 && result_o.next_action == ACT_SWITCH_MUX, "Dropped sample not reported as a switch with zero value")
  `RASCAN_ASSERT(a_valid_sticky, !empty && pop && result_o.all_valid |=> empty || result_o.all_valid, "Scan complete flag fell")

endmodule

bind ratiometric_adc_scan_sequencer rascan_checker u_checker (.*);

/* tb/ratiometric_adc_scan_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// Scan sequencer testbench
// Drives conversion and read beats through the input queue, predicts every
// result beat from a behavioural copy of the sequencer and compares fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ratiometric_adc_scan_sequencer_tb;
  import rascan_pkg::*;

  localparam int ChanPerBank = 4;
  localparam int Banks       = 4;
  localparam int Depth       = 16;
  localparam int CycleLimit  = 1500000;

  // Behavioural sequencer and queue of predicted result beats.
  class scan_scoreboard;
    logic [2:0]  src_idx;
    logic [9:0]  ref_reading;
    logic [19:0] table_q [Depth];
    logic        complete;
    logic [9:0]  fscale;
    result_t     pending_q [$];
    int          errors;
    int          checked;

    function void clear();
      src_idx = '0;
      ref_reading = '0;
      foreach (table_q[i]) table_q[i] = '0;
      complete = 1'b0;
      fscale = FULL_SCALE_RESET;
      errors = 0;
      checked = 0;
    endfunction

    // Work out the result of one accepted input beat and update state.
    function void note_input(in_item_t it);
      result_t r;
      int unsigned slot;
      logic [29:0] prod;
      r = '0;
      if (it.command == CMD_READ) begin
        if (it.read_index < Depth) r.read_value = table_q[it.read_index];
        r.next_action = ACT_NONE;
      end else begin
        if (src_idx == 0) begin
          ref_reading = it.sample;
          r.read_value = {10'd0, it.sample};
        end else begin
          slot = it.channel + ChanPerBank * (src_idx - 1);
          if (it.channel >= ChanPerBank || slot >= Depth) begin
            r.channel_error = 1'b1;
          end else begin
            prod = it.sample * fscale;
            if (ref_reading != 0) r.read_value = 20'(prod / ref_reading);
            else r.read_value = {10'd0, it.sample};
            table_q[slot] = r.read_value;
          end
        end
        if (src_idx == 0 || it.channel >= ChanPerBank - 1) begin
          src_idx = src_idx + 3'd1;
          if (src_idx > Banks || src_idx == 0) begin
            src_idx = '0;
            complete = 1'b1;
          end
          r.next_action = ACT_SWITCH_MUX;
        end else begin
          r.next_action = ACT_NEXT_CHANNEL;
          r.next_channel = it.channel + 3'd1;
        end
      end
      r.mux_pins = PIN_CODES[src_idx];
      r.all_valid = complete;
      pending_q.push_back(r);
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_result(result_t got);
      result_t e;
      if (pending_q.size() == 0) begin
        $error("Result beat with no prediction waiting: %h", got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.next_action !== e.next_action) begin
        $error("next_action expected %0d got %0d", e.next_action, got.next_action);
        errors++;
      end
      if (got.next_channel !== e.next_channel) begin
        $error("next_channel expected %0d got %0d", e.next_channel, got.next_channel);
        errors++;
      end
      if (got.mux_pins !== e.mux_pins) begin
        $error("mux_pins expected %0d got %0d", e.mux_pins, got.mux_pins);
        errors++;
      end
      if (got.all_valid !== e.all_valid) begin
        $error("all_valid expected %0d got %0d", e.all_valid, got.all_valid);
        errors++;
      end
      if (got.read_value !== e.read_value) begin
        $error("read_value expected %0d got %0d", e.read_value, got.read_value);
        errors++;
      end
      if (got.channel_error !== e.channel_error) begin
        $error("channel_error expected %0d got %0d", e.channel_error, got.channel_error);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  in_item_t   in_item_i;
  logic       empty;
  logic       pop;
  result_t    result_o;
  logic       cfg_we_i;
  logic [9:0] cfg_wdata_i;

  scan_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned beats_sent;

  ratiometric_adc_scan_sequencer #(
    .CHANNELS_PER_BANK(ChanPerBank),
    .BANK_COUNT(Banks),
    .TABLE_DEPTH(Depth)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_item_i(in_item_i),
    .empty(empty),
    .pop(pop),
    .result_o(result_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random pops, with checking on every accepted beat.
  initial begin : result_sink
    int gap;
    pop = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && !empty));
      sb.check_result(result_o);
    end
  end

  // Push one beat, holding push until the queue takes it.
  task automatic send_beat(in_item_t it, bit allow_gap);
    int gap;
    gap = (allow_gap && $urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
    beats_sent++;
  endtask

  // Wait until every prediction has been matched, plus settle time.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_full_scale(logic [9:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.fscale = v;
  endtask

  function automatic in_item_t conv(logic [2:0] ch, logic [9:0] s);
    in_item_t it;
    it = '0;
    it.command = CMD_CONVERSION;
    it.channel = ch;
    it.sample = s;
    it.read_index = 4'($urandom);
    return it;
  endfunction

  function automatic in_item_t rd(logic [3:0] idx);
    in_item_t it;
    it = '0;
    it.command = CMD_READ;
    it.read_index = idx;
    it.channel = 3'($urandom);
    it.sample = 10'($urandom);
    return it;
  endfunction

  // One full well-formed scan, with occasional stray beats mixed in.
  task automatic random_scan(bit allow_gap);
    logic [9:0] s;
    s = ($urandom_range(0, 7) == 0) ? 10'd0 :
        ($urandom_range(0, 7) == 0) ? 10'h3FF : 10'($urandom);
    send_beat(conv(3'($urandom), s), allow_gap);
    for (int b = 0; b < Banks; b++) begin
      for (int c = 0; c < ChanPerBank; c++) begin
        if ($urandom_range(0, 9) == 0) send_beat(rd(4'($urandom)), allow_gap);
        if ($urandom_range(0, 19) == 0) begin
          // Broken sequence: a channel beyond the bank ends it early.
          send_beat(conv(3'($urandom_range(ChanPerBank, 7)), 10'($urandom)), allow_gap);
          break;
        end
        send_beat(conv(3'(c), 10'($urandom)), allow_gap);
      end
    end
  endtask

  // Stimulus.
  initial begin : stimulus
    logic [9:0] fs_set [5];
    sb = new();
    sb.clear();
    beats_sent = 0;
    push = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: read before any write, zero reference, extremes, bad channels.
    send_beat(rd(4'd0), 0);
    send_beat(rd(4'd15), 0);
    send_beat(conv(3'd7, 10'd0), 0);
    send_beat(conv(3'd0, 10'h3FF), 0);
    send_beat(conv(3'd1, 10'd0), 0);
    send_beat(conv(3'd2, 10'd512), 0);
    send_beat(conv(3'd3, 10'd1), 0);
    send_beat(conv(3'd0, 10'h3FF), 0);
    send_beat(conv(3'd7, 10'h155), 0);
    send_beat(conv(3'd0, 10'h2AA), 0);
    send_beat(conv(3'd4, 10'd9), 0);
    send_beat(conv(3'd0, 10'h3FF), 0);
    send_beat(conv(3'd3, 10'd77), 0);
    send_beat(conv(3'd0, 10'd1), 0);
    send_beat(conv(3'd1, 10'h3FF), 0);
    send_beat(rd(4'd4), 0);
    send_beat(rd(4'd0), 0);
    send_beat(conv(3'd2, 10'h3FF), 0);
    send_beat(conv(3'd3, 10'd100), 0);
    send_beat(rd(4'd12), 0);
    drain();

    // Random scans under several full-scale settings, extremes included.
    fs_set = '{10'd1, 10'h3FF, 10'd512, 10'h2AA, 10'd0};
    for (int p = 0; p < 5; p++) begin
      if (p < 4) write_full_scale(fs_set[p]);
      else write_full_scale(10'($urandom_range(2, 1022)));
      for (int k = 0; k < 17; k++) random_scan(k % 4 != 3);
      // Sender holds off until every predicted result is back.
      drain();
    end
    while (beats_sent < 1450) begin
      if ($urandom_range(0, 3) == 0) send_beat(rd(4'($urandom)), 1);
      else send_beat(conv(3'($urandom), 10'($urandom)), 1);
    end
    drain();

    $display("Sent %0d beats and checked %0d results over five full-scale settings.",
             beats_sent, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
